// ===== src/npsa_pkg.sv =====
// ----------------------------------------------------------------------------
// npsa_pkg
// Shared constants, command and status types for the nonlinear phase
// spectrum accumulator.
// ----------------------------------------------------------------------------
package npsa_pkg;

    localparam int MAX_PAIRS = 64;

    localparam int SUM_W     = 23;
    localparam int CONTRIB_W = 17;

    // saturation level of the running sum, MAX_PAIRS in Q7.16
    localparam logic [SUM_W-1:0] SUM_CAP = SUM_W'(MAX_PAIRS * 65536);

    // log2(e) and ln(2) in Q30, one in Q30
    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [29:0] LN2_Q30   = 30'd744261118;
    localparam logic [31:0] ONE_Q30   = 32'h4000_0000;

    // number of Horner terms of the exponential series
    localparam logic [3:0] HORNER_TERMS = 4'd10;

    // last step index of the iterative units
    localparam logic [5:0] SQRT_LAST = 6'd31;
    localparam logic [5:0] DIV_LAST  = 6'd63;
    localparam logic [5:0] KDIV_LAST = 6'd31;

    // multiplier operand selection
    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_AR_BR,
        MUL_AI_BI,
        MUL_AI_BR,
        MUL_AR_BI,
        MUL_XR_SQ,
        MUL_XI_SQ,
        MUL_XR_SC,
        MUL_XI_SS,
        MUL_W_S,
        MUL_ZLO_L,
        MUL_ZHI_L,
        MUL_G_LN2,
        MUL_T_R
    } mul_sel_t;

    // accumulator operation on the registered product
    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB,
        ACC_ADD_HI
    } acc_op_t;

    // datapath register operation
    typedef enum logic [4:0] {
        DP_NOP,
        DP_LOAD_IN,
        DP_STORE_XR,
        DP_STORE_XI,
        DP_SQ_LOAD_ACC,
        DP_SQ_LOAD_Q,
        DP_SQ_STEP,
        DP_STORE_MAG,
        DP_DV_LOAD_U,
        DP_DV_STEP,
        DP_STORE_Z,
        DP_STORE_N,
        DP_STORE_T,
        DP_DV_LOAD_K,
        DP_R_UPDATE,
        DP_DV_LOAD_FIN,
        DP_CONTRIB_FIN,
        DP_CONTRIB_ZERO,
        DP_DEGEN,
        DP_ACCUM,
        DP_EMIT
    } dp_op_t;

    typedef struct packed {
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        dp_op_t   dp_op;
    } npsa_cmd_t;

    typedef struct packed {
        logic mag_zero;
        logic n_big;
        logic k_one;
        logic last;
        logic out_busy;
    } npsa_status_t;

endpackage

// ===== src/npsa_datapath.sv =====
// ----------------------------------------------------------------------------
// npsa_datapath
// Input registers, shared multiplier with accumulator, bit-serial square
// root, restoring divider and the running sum with its output register.
// ----------------------------------------------------------------------------
module npsa_datapath
    import npsa_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  npsa_cmd_t             cmd,
    output npsa_status_t          status,
    input  logic signed [15:0]    s_first_re,
    input  logic signed [15:0]    s_first_im,
    input  logic signed [15:0]    s_second_re,
    input  logic signed [15:0]    s_second_im,
    input  logic signed [15:0]    s_steer_cos,
    input  logic signed [15:0]    s_steer_sin,
    input  logic [15:0]           s_pair_weight,
    input  logic                  s_last_pair,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [SUM_W-1:0]      m_spectrum_value,
    output logic                  m_degenerate_seen
);

    // input item
    logic signed [15:0] ar_reg, ai_reg, br_reg, bi_reg, sc_reg, ss_reg;
    logic signed [15:0] ar_next, ai_next, br_next, bi_next, sc_next, ss_next;
    logic [15:0]        w_reg, w_next;
    logic               last_reg, last_next;

    // cross-spectrum
    logic signed [32:0] xr_reg, xi_reg, xr_next, xi_next;
    logic [32:0]        xr_abs, xi_abs;

    // multiplier and accumulator
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] mul_p;
    logic signed [67:0] prod_reg, prod_next;
    logic signed [67:0] acc_reg, acc_next;

    // square root unit
    logic [63:0] sq_val_reg, sq_res_reg, sq_bit_reg;
    logic [63:0] sq_val_next, sq_res_next, sq_bit_next;
    logic [63:0] sq_sum;

    // divider unit
    logic [63:0] dv_q_reg, dv_q_next;
    logic [31:0] dv_rem_reg, dv_rem_next;
    logic [31:0] dv_d_reg, dv_d_next;
    logic [32:0] dv_rem2;
    logic        dv_ge;

    // intermediate values
    logic [31:0]           mag_reg, mag_next;
    logic [47:0]           z_reg, z_next;
    logic [4:0]            n_reg, n_next;
    logic [29:0]           t_reg, t_next;
    logic [31:0]           r_reg, r_next;
    logic [3:0]            k_reg, k_next;
    logic [CONTRIB_W-1:0]  contrib_reg, contrib_next;
    logic signed [51:0]    td;
    logic [51:0]           t_abs;
    logic [26:0]           g_diff;
    logic [30:0]           g_val;
    logic [31:0]           v_val;
    logic [SUM_W:0]        sum_wide;

    // running state and output register
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic             flag_reg, flag_next;
    logic             m_valid_reg, m_valid_next;
    logic [SUM_W-1:0] m_value_reg, m_value_next;
    logic             m_flag_reg, m_flag_next;

    assign xr_abs = xr_reg[32] ? 33'(-xr_reg) : 33'(xr_reg);
    assign xi_abs = xi_reg[32] ? 33'(-xi_reg) : 33'(xi_reg);

    // |2*mag*2^14 - 2*p| with p held in the accumulator
    assign td    = $signed({5'b0, mag_reg, 15'b0}) - $signed({acc_reg[50:0], 1'b0});
    assign t_abs = td[51] ? 52'(-td) : 52'(td);

    // fractional part of 2*z*log2(e) sits in the accumulator
    assign g_diff = 27'h400_0000 - {1'b0, acc_reg[54:29]};
    assign g_val  = {g_diff, 4'b0};

    // e^(-2z) in Q30
    assign v_val = r_reg >> (6'(n_reg) + 6'd1);

    // multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_sel)
            MUL_AR_BR: begin mul_a = 34'(ar_reg); mul_b = 34'(br_reg); end
            MUL_AI_BI: begin mul_a = 34'(ai_reg); mul_b = 34'(bi_reg); end
            MUL_AI_BR: begin mul_a = 34'(ai_reg); mul_b = 34'(br_reg); end
            MUL_AR_BI: begin mul_a = 34'(ar_reg); mul_b = 34'(bi_reg); end
            MUL_XR_SQ: begin mul_a = {1'b0, xr_abs}; mul_b = {1'b0, xr_abs}; end
            MUL_XI_SQ: begin mul_a = {1'b0, xi_abs}; mul_b = {1'b0, xi_abs}; end
            MUL_XR_SC: begin mul_a = 34'(xr_reg); mul_b = 34'(sc_reg); end
            MUL_XI_SS: begin mul_a = 34'(xi_reg); mul_b = 34'(ss_reg); end
            MUL_W_S:   begin mul_a = {18'b0, w_reg}; mul_b = {2'b0, sq_res_reg[31:0]}; end
            MUL_ZLO_L: begin mul_a = {2'b0, z_reg[31:0]}; mul_b = {3'b0, LOG2E_Q30}; end
            MUL_ZHI_L: begin mul_a = {18'b0, z_reg[47:32]}; mul_b = {3'b0, LOG2E_Q30}; end
            MUL_G_LN2: begin mul_a = {3'b0, g_val}; mul_b = {4'b0, LN2_Q30}; end
            MUL_T_R:   begin mul_a = {4'b0, t_reg}; mul_b = {2'b0, r_reg}; end
            default:   begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign mul_p     = mul_a * mul_b;
    assign prod_next = mul_p;

    // accumulator
    always_comb begin
        case (cmd.acc_op)
            ACC_LOAD:   acc_next = prod_reg;
            ACC_ADD:    acc_next = acc_reg + prod_reg;
            ACC_SUB:    acc_next = acc_reg - prod_reg;
            ACC_ADD_HI: acc_next = acc_reg + (prod_reg <<< 32);
            default:    acc_next = acc_reg;
        endcase
    end

    // square root and divider step values
    assign sq_sum  = sq_res_reg + sq_bit_reg;
    assign dv_rem2 = {dv_rem_reg, dv_q_reg[63]};
    assign dv_ge   = dv_rem2 >= {1'b0, dv_d_reg};

    // saturating sum
    assign sum_wide = {1'b0, sum_reg} + {7'b0, contrib_reg};

    // register operations
    always_comb begin
        ar_next      = ar_reg;
        ai_next      = ai_reg;
        br_next      = br_reg;
        bi_next      = bi_reg;
        sc_next      = sc_reg;
        ss_next      = ss_reg;
        w_next       = w_reg;
        last_next    = last_reg;
        xr_next      = xr_reg;
        xi_next      = xi_reg;
        sq_val_next  = sq_val_reg;
        sq_res_next  = sq_res_reg;
        sq_bit_next  = sq_bit_reg;
        dv_q_next    = dv_q_reg;
        dv_rem_next  = dv_rem_reg;
        dv_d_next    = dv_d_reg;
        mag_next     = mag_reg;
        z_next       = z_reg;
        n_next       = n_reg;
        t_next       = t_reg;
        r_next       = r_reg;
        k_next       = k_reg;
        contrib_next = contrib_reg;
        sum_next     = sum_reg;
        flag_next    = flag_reg;
        m_value_next = m_value_reg;
        m_flag_next  = m_flag_reg;
        m_valid_next = m_valid_reg && !m_ready;
        case (cmd.dp_op)
            DP_LOAD_IN: begin
                ar_next   = s_first_re;
                ai_next   = s_first_im;
                br_next   = s_second_re;
                bi_next   = s_second_im;
                sc_next   = s_steer_cos;
                ss_next   = s_steer_sin;
                w_next    = s_pair_weight;
                last_next = s_last_pair;
            end
            DP_STORE_XR: xr_next = acc_reg[32:0];
            DP_STORE_XI: xi_next = acc_reg[32:0];
            DP_SQ_LOAD_ACC: begin
                sq_val_next = acc_reg[63:0];
                sq_res_next = '0;
                sq_bit_next = 64'h4000_0000_0000_0000;
            end
            DP_SQ_LOAD_Q: begin
                sq_val_next = dv_q_reg;
                sq_res_next = '0;
                sq_bit_next = 64'h4000_0000_0000_0000;
            end
            DP_SQ_STEP: begin
                if (sq_val_reg >= sq_sum) begin
                    sq_val_next = sq_val_reg - sq_sum;
                    sq_res_next = (sq_res_reg >> 1) + sq_bit_reg;
                end else begin
                    sq_res_next = sq_res_reg >> 1;
                end
                sq_bit_next = sq_bit_reg >> 2;
            end
            DP_STORE_MAG: mag_next = sq_res_reg[31:0];
            DP_DV_LOAD_U: begin
                dv_q_next   = {t_abs[49:0], 14'b0};
                dv_rem_next = '0;
                dv_d_next   = mag_reg;
            end
            DP_DV_STEP: begin
                dv_rem_next = dv_ge ? 32'(dv_rem2 - {1'b0, dv_d_reg}) : dv_rem2[31:0];
                dv_q_next   = {dv_q_reg[62:0], dv_ge};
            end
            DP_STORE_Z: z_next = prod_reg[47:0];
            DP_STORE_N: n_next = acc_reg[59:55];
            DP_STORE_T: begin
                t_next = prod_reg[59:30];
                r_next = ONE_Q30;
                k_next = HORNER_TERMS;
            end
            DP_DV_LOAD_K: begin
                dv_q_next   = {prod_reg[61:30], 32'b0};
                dv_rem_next = '0;
                dv_d_next   = {28'b0, k_reg};
            end
            DP_R_UPDATE: begin
                r_next = ONE_Q30 + dv_q_reg[31:0];
                k_next = k_reg - 4'd1;
            end
            DP_DV_LOAD_FIN: begin
                dv_q_next   = {15'b0, v_val, 17'b0};
                dv_rem_next = '0;
                dv_d_next   = ONE_Q30 + v_val;
            end
            DP_CONTRIB_FIN:  contrib_next = dv_q_reg[CONTRIB_W-1:0];
            DP_CONTRIB_ZERO: contrib_next = '0;
            DP_DEGEN: begin
                contrib_next = '0;
                flag_next    = 1'b1;
            end
            DP_ACCUM: begin
                if (sum_wide > {1'b0, SUM_CAP}) begin
                    sum_next = SUM_CAP;
                end else begin
                    sum_next = sum_wide[SUM_W-1:0];
                end
            end
            DP_EMIT: begin
                m_valid_next = 1'b1;
                m_value_next = sum_reg;
                m_flag_next  = flag_reg;
                sum_next     = '0;
                flag_next    = 1'b0;
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg     <= '0;
            flag_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            sum_reg     <= sum_next;
            flag_reg    <= flag_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        ar_reg      <= ar_next;
        ai_reg      <= ai_next;
        br_reg      <= br_next;
        bi_reg      <= bi_next;
        sc_reg      <= sc_next;
        ss_reg      <= ss_next;
        w_reg       <= w_next;
        last_reg    <= last_next;
        xr_reg      <= xr_next;
        xi_reg      <= xi_next;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
        sq_val_reg  <= sq_val_next;
        sq_res_reg  <= sq_res_next;
        sq_bit_reg  <= sq_bit_next;
        dv_q_reg    <= dv_q_next;
        dv_rem_reg  <= dv_rem_next;
        dv_d_reg    <= dv_d_next;
        mag_reg     <= mag_next;
        z_reg       <= z_next;
        n_reg       <= n_next;
        t_reg       <= t_next;
        r_reg       <= r_next;
        k_reg       <= k_next;
        contrib_reg <= contrib_next;
        m_value_reg <= m_value_next;
        m_flag_reg  <= m_flag_next;
    end

    // status to the controller
    assign status.mag_zero = (mag_reg == '0);
    assign status.n_big    = |acc_reg[63:60];
    assign status.k_one    = (k_reg == 4'd1);
    assign status.last     = last_reg;
    assign status.out_busy = m_valid_reg && !m_ready;

    assign m_valid           = m_valid_reg;
    assign m_spectrum_value  = m_value_reg;
    assign m_degenerate_seen = m_flag_reg;

endmodule

// ===== src/npsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// npsa_ctrl
// Sequencer that steps the datapath through cross-spectrum, magnitude,
// normalization, nonlinearity and accumulation for each transaction.
// ----------------------------------------------------------------------------
module npsa_ctrl
    import npsa_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  npsa_status_t status,
    output npsa_cmd_t    cmd
);

    typedef enum logic [5:0] {
        ST_IDLE,
        ST_X0, ST_X1, ST_X2, ST_X3, ST_X4, ST_X5, ST_X6, ST_X7,
        ST_P0, ST_P1, ST_P2,
        ST_SQ1, ST_MAG, ST_MAGCHK, ST_DIVU,
        ST_SQ2_LD, ST_SQ2, ST_ZMUL, ST_ZST,
        ST_XM0, ST_XM1, ST_XM2, ST_XCHK, ST_TST,
        ST_HR_MUL, ST_HR_LD, ST_HR_DIV, ST_HR_UPD,
        ST_FIN_LD, ST_FIN_DIV, ST_FIN_ST, ST_ACC
    } state_t;

    typedef enum logic [0:0] {
        OUT_READY,
        OUT_EMIT
    } emit_t;

    state_t    state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    emit_t     emit_reg, emit_next;

    // next state and command decode
    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        emit_next   = emit_reg;
        cmd.mul_sel = MUL_NONE;
        cmd.acc_op  = ACC_HOLD;
        cmd.dp_op   = DP_NOP;
        unique case (state_reg)
            ST_IDLE: begin
                if (emit_reg == OUT_EMIT) begin
                    if (!status.out_busy) begin
                        cmd.dp_op = DP_EMIT;
                        emit_next = OUT_READY;
                    end
                end else if (s_valid) begin
                    cmd.dp_op  = DP_LOAD_IN;
                    state_next = ST_X0;
                end
            end
            ST_X0: begin
                cmd.mul_sel = MUL_AR_BR;
                state_next  = ST_X1;
            end
            ST_X1: begin
                cmd.mul_sel = MUL_AI_BI;
                cmd.acc_op  = ACC_LOAD;
                state_next  = ST_X2;
            end
            ST_X2: begin
                cmd.mul_sel = MUL_AI_BR;
                cmd.acc_op  = ACC_ADD;
                state_next  = ST_X3;
            end
            ST_X3: begin
                cmd.mul_sel = MUL_AR_BI;
                cmd.acc_op  = ACC_LOAD;
                cmd.dp_op   = DP_STORE_XR;
                state_next  = ST_X4;
            end
            ST_X4: begin
                cmd.acc_op = ACC_SUB;
                state_next = ST_X5;
            end
            ST_X5: begin
                cmd.dp_op  = DP_STORE_XI;
                state_next = ST_X6;
            end
            ST_X6: begin
                cmd.mul_sel = MUL_XR_SQ;
                state_next  = ST_X7;
            end
            ST_X7: begin
                cmd.mul_sel = MUL_XI_SQ;
                cmd.acc_op  = ACC_LOAD;
                state_next  = ST_P0;
            end
            ST_P0: begin
                cmd.acc_op = ACC_ADD;
                state_next = ST_P1;
            end
            ST_P1: begin
                // energy goes to the root unit, steered product follows
                cmd.dp_op   = DP_SQ_LOAD_ACC;
                cmd.mul_sel = MUL_XR_SC;
                state_next  = ST_P2;
            end
            ST_P2: begin
                cmd.mul_sel = MUL_XI_SS;
                cmd.acc_op  = ACC_LOAD;
                state_next  = ST_SQ1;
                cnt_next    = '0;
            end
            ST_SQ1: begin
                if (cnt_reg == '0) begin
                    cmd.acc_op = ACC_SUB;
                end
                cmd.dp_op = DP_SQ_STEP;
                cnt_next  = cnt_reg + 6'd1;
                if (cnt_reg == SQRT_LAST) begin
                    state_next = ST_MAG;
                end
            end
            ST_MAG: begin
                cmd.dp_op  = DP_STORE_MAG;
                state_next = ST_MAGCHK;
            end
            ST_MAGCHK: begin
                cnt_next = '0;
                if (status.mag_zero) begin
                    cmd.dp_op  = DP_DEGEN;
                    state_next = ST_ACC;
                end else begin
                    cmd.dp_op  = DP_DV_LOAD_U;
                    state_next = ST_DIVU;
                end
            end
            ST_DIVU: begin
                cmd.dp_op = DP_DV_STEP;
                cnt_next  = cnt_reg + 6'd1;
                if (cnt_reg == DIV_LAST) begin
                    state_next = ST_SQ2_LD;
                end
            end
            ST_SQ2_LD: begin
                cmd.dp_op  = DP_SQ_LOAD_Q;
                cnt_next   = '0;
                state_next = ST_SQ2;
            end
            ST_SQ2: begin
                cmd.dp_op = DP_SQ_STEP;
                cnt_next  = cnt_reg + 6'd1;
                if (cnt_reg == SQRT_LAST) begin
                    state_next = ST_ZMUL;
                end
            end
            ST_ZMUL: begin
                cmd.mul_sel = MUL_W_S;
                state_next  = ST_ZST;
            end
            ST_ZST: begin
                cmd.dp_op  = DP_STORE_Z;
                state_next = ST_XM0;
            end
            ST_XM0: begin
                cmd.mul_sel = MUL_ZLO_L;
                state_next  = ST_XM1;
            end
            ST_XM1: begin
                cmd.mul_sel = MUL_ZHI_L;
                cmd.acc_op  = ACC_LOAD;
                state_next  = ST_XM2;
            end
            ST_XM2: begin
                cmd.acc_op = ACC_ADD_HI;
                state_next = ST_XCHK;
            end
            ST_XCHK: begin
                // exponent too large: the tail is below one lsb
                if (status.n_big) begin
                    cmd.dp_op  = DP_CONTRIB_ZERO;
                    state_next = ST_ACC;
                end else begin
                    cmd.dp_op   = DP_STORE_N;
                    cmd.mul_sel = MUL_G_LN2;
                    state_next  = ST_TST;
                end
            end
            ST_TST: begin
                cmd.dp_op  = DP_STORE_T;
                state_next = ST_HR_MUL;
            end
            ST_HR_MUL: begin
                cmd.mul_sel = MUL_T_R;
                state_next  = ST_HR_LD;
            end
            ST_HR_LD: begin
                cmd.dp_op  = DP_DV_LOAD_K;
                cnt_next   = '0;
                state_next = ST_HR_DIV;
            end
            ST_HR_DIV: begin
                cmd.dp_op = DP_DV_STEP;
                cnt_next  = cnt_reg + 6'd1;
                if (cnt_reg == KDIV_LAST) begin
                    state_next = ST_HR_UPD;
                end
            end
            ST_HR_UPD: begin
                cmd.dp_op = DP_R_UPDATE;
                if (status.k_one) begin
                    state_next = ST_FIN_LD;
                    cnt_next   = '0;
                end else begin
                    state_next = ST_HR_MUL;
                end
            end
            ST_FIN_LD: begin
                // load the final quotient operands
                cmd.dp_op  = DP_DV_LOAD_FIN;
                cnt_next   = '0;
                state_next = ST_FIN_DIV;
            end
            ST_FIN_DIV: begin
                cmd.dp_op = DP_DV_STEP;
                cnt_next  = cnt_reg + 6'd1;
                if (cnt_reg == DIV_LAST) begin
                    state_next = ST_FIN_ST;
                end
            end
            ST_FIN_ST: begin
                cmd.dp_op  = DP_CONTRIB_FIN;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.dp_op  = DP_ACCUM;
                state_next = ST_IDLE;
                if (status.last) begin
                    emit_next = OUT_EMIT;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE) && (emit_reg == OUT_READY);

    // state and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            emit_reg  <= OUT_READY;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            emit_reg  <= emit_next;
        end
    end

endmodule

// ===== src/nonlinear_phase_spectrum_accumulator_unit.sv =====
// ----------------------------------------------------------------------------
// nonlinear_phase_spectrum_accumulator_unit
// Accumulates the nonlinear phase-transform spatial spectrum over the
// microphone pairs of one bin and angle.
// ----------------------------------------------------------------------------
// One transaction at a time: the time a pair takes is set by the bit-serial
// units that one shared 34x34 multiplier feeds: two 32-step square roots, a
// 64-step divide for the normalization, ten Horner terms (each a 32-step
// divide by the term index) and a final divide. A pair with a zero
// cross-spectrum skips the divides and the second root, and one whose exponent
// underflows skips the Horner terms and the final divide. The sum is Q7.16 and
// saturates at MAX_PAIRS; a result transaction leaves on the pair marked last,
// and the next pair is taken while that result still waits in the output
// register, unless a second result would have to overwrite it.
module nonlinear_phase_spectrum_accumulator_unit
    import npsa_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_first_re,
    input  logic signed [15:0] s_first_im,
    input  logic signed [15:0] s_second_re,
    input  logic signed [15:0] s_second_im,
    input  logic signed [15:0] s_steer_cos,
    input  logic signed [15:0] s_steer_sin,
    input  logic [15:0]        s_pair_weight,
    input  logic               s_last_pair,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [SUM_W-1:0]   m_spectrum_value,
    output logic               m_degenerate_seen
);

    npsa_cmd_t    cmd;
    npsa_status_t status;

    // sequencer
    npsa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // arithmetic and result register
    npsa_datapath u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .s_first_re        (s_first_re),
        .s_first_im        (s_first_im),
        .s_second_re       (s_second_re),
        .s_second_im       (s_second_im),
        .s_steer_cos       (s_steer_cos),
        .s_steer_sin       (s_steer_sin),
        .s_pair_weight     (s_pair_weight),
        .s_last_pair       (s_last_pair),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_spectrum_value  (m_spectrum_value),
        .m_degenerate_seen (m_degenerate_seen)
    );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the nonlinear phase spectrum accumulator against a bit-exact
// predictor of the fixed-point path. Pairs are sent over the valid/ready
// input channel, including directed extremes, zero cross-spectra and sum
// saturation, then random groups of pairs under several idle and stall
// mixes. Each result transaction is compared field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import npsa_pkg::*;

    localparam int  CLK_HALF    = 6;
    localparam int  CYCLE_LIMIT = 8_000_000;
    localparam int  DRAIN_WAIT  = 700;
    localparam logic [63:0] LOG2E_TB = 64'd1549082005;
    localparam logic [63:0] LN2_TB   = 64'd744261118;
    localparam logic [63:0] ONE_TB   = 64'h4000_0000;
    localparam logic [31:0] CAP_TB   = 32'(MAX_PAIRS) << 16;

    typedef struct {
        logic signed [15:0] first_re;
        logic signed [15:0] first_im;
        logic signed [15:0] second_re;
        logic signed [15:0] second_im;
        logic signed [15:0] steer_cos;
        logic signed [15:0] steer_sin;
        logic [15:0]        pair_weight;
        logic               last_pair;
    } pair_t;

    typedef struct {
        logic [SUM_W-1:0] spectrum_value;
        logic             degenerate_seen;
    } spectrum_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic signed [15:0] s_first_re;
    logic signed [15:0] s_first_im;
    logic signed [15:0] s_second_re;
    logic signed [15:0] s_second_im;
    logic signed [15:0] s_steer_cos;
    logic signed [15:0] s_steer_sin;
    logic [15:0]        s_pair_weight;
    logic               s_last_pair;
    logic               m_valid;
    logic               m_ready;
    logic [SUM_W-1:0]   m_spectrum_value;
    logic               m_degenerate_seen;

    spectrum_t expected_spectra[$];
    logic [31:0] pred_sum;
    logic        pred_degen;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          error_count;
    int          cycle_count;

    nonlinear_phase_spectrum_accumulator_unit u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_first_re        (s_first_re),
        .s_first_im        (s_first_im),
        .s_second_re       (s_second_re),
        .s_second_im       (s_second_im),
        .s_steer_cos       (s_steer_cos),
        .s_steer_sin       (s_steer_sin),
        .s_pair_weight     (s_pair_weight),
        .s_last_pair       (s_last_pair),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_spectrum_value  (m_spectrum_value),
        .m_degenerate_seen (m_degenerate_seen)
    );

    // clock
    always begin
        aclk = 1'b1;
        #CLK_HALF;
        aclk = 1'b0;
        #CLK_HALF;
    end

    // integer square root, floor
    function automatic logic [63:0] floor_sqrt(input logic [63:0] val);
        logic [63:0] root;
        logic [63:0] probe;
        root  = '0;
        probe = 64'h4000_0000_0000_0000;
        while (probe > val) probe >>= 2;
        while (probe != 0) begin
            if (val >= root + probe) begin
                val  -= root + probe;
                root  = (root >> 1) + probe;
            end else begin
                root >>= 1;
            end
            probe >>= 2;
        end
        return root;
    endfunction

    function automatic logic [63:0] magnitude64(input longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // 1 - tanh(z), z in Q26, result in Q16
    function automatic logic [31:0] soft_contrib(input logic [63:0] z);
        logic [63:0] x, n, f, g, t, r, v;
        x = (z * LOG2E_TB) >> 29;
        n = x >> 26;
        f = x & ((64'd1 << 26) - 1);
        g = ((64'd1 << 26) - f) << 4;
        t = (g * LN2_TB) >> 30;
        r = ONE_TB;
        for (int k = 10; k >= 1; k--)
            r = ONE_TB + ((t * r) >> 30) / 64'(k);
        v = (n >= 32) ? 64'd0 : (r >> (n + 1));
        return 32'(((2 * v) << 16) / (ONE_TB + v));
    endfunction

    // accumulate one pair, report whether a result leaves
    function automatic logic accumulate_pair(input pair_t pr, output spectrum_t res);
        longint      ar, ai, br, bi, sc, ss, xr, xi, p;
        logic [63:0] mag, t, u, s;
        logic [31:0] contrib;
        ar = pr.first_re;  ai = pr.first_im;
        br = pr.second_re; bi = pr.second_im;
        sc = pr.steer_cos; ss = pr.steer_sin;
        xr = ar * br + ai * bi;
        xi = ai * br - ar * bi;
        mag = floor_sqrt(magnitude64(xr) * magnitude64(xr)
                         + magnitude64(xi) * magnitude64(xi));
        contrib = '0;
        if (mag == 0) begin
            pred_degen = 1'b1;
        end else begin
            p = xr * sc - xi * ss;
            t = magnitude64(longint'(mag) * 2 * 16384 - 2 * p);
            u = (t << 14) / mag;
            s = floor_sqrt(u);
            contrib = soft_contrib(64'(pr.pair_weight) * s);
        end
        pred_sum += contrib;
        if (pred_sum > CAP_TB) pred_sum = CAP_TB;
        res.spectrum_value  = pred_sum[SUM_W-1:0];
        res.degenerate_seen = pred_degen;
        if (pr.last_pair) begin
            pred_sum   = '0;
            pred_degen = 1'b0;
        end
        return pr.last_pair;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // send one pair transaction; called at a rising edge
    task automatic send_pair(input pair_t pr);
        spectrum_t res;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_first_re    <= pr.first_re;
        s_first_im    <= pr.first_im;
        s_second_re   <= pr.second_re;
        s_second_im   <= pr.second_im;
        s_steer_cos   <= pr.steer_cos;
        s_steer_sin   <= pr.steer_sin;
        s_pair_weight <= pr.pair_weight;
        s_last_pair   <= pr.last_pair;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (accumulate_pair(pr, res)) expected_spectra.push_back(res);
    endtask

    task automatic wait_results_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_spectra.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_word();
        case ($urandom_range(7))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            3:       return 16'(16'(int'($urandom_range(64))) - 16'd32);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic pair_t random_pair(input logic last);
        pair_t pr;
        int    ang;
        pr.first_re  = pick_word();
        pr.first_im  = pick_word();
        pr.second_re = pick_word();
        pr.second_im = pick_word();
        if ($urandom_range(15) == 0) begin
            pr.first_re = '0;
            pr.first_im = '0;
        end
        // mostly unit-circle steering, sometimes any pattern
        if ($urandom_range(9) == 0) begin
            pr.steer_cos = 16'($urandom);
            pr.steer_sin = 16'($urandom);
        end else begin
            ang = $urandom_range(359);
            pr.steer_cos = 16'($rtoi(16384.0 * $cos(ang * 3.14159265 / 180.0)));
            pr.steer_sin = 16'($rtoi(16384.0 * $sin(ang * 3.14159265 / 180.0)));
        end
        case ($urandom_range(3))
            0:       pr.pair_weight = 16'($urandom);
            1:       pr.pair_weight = 16'($urandom_range(0, 255));
            default: pr.pair_weight = 16'($urandom_range(0, 16384));
        endcase
        pr.last_pair = last;
        return pr;
    endfunction

    function automatic pair_t make_pair(input int fr, fi, sr, si, sc, ss, w,
                                        input logic last);
        pair_t pr;
        pr.first_re    = 16'(fr);
        pr.first_im    = 16'(fi);
        pr.second_re   = 16'(sr);
        pr.second_im   = 16'(si);
        pr.steer_cos   = 16'(sc);
        pr.steer_sin   = 16'(ss);
        pr.pair_weight = 16'(w);
        pr.last_pair   = last;
        return pr;
    endfunction

    // field extremes, aligned and opposed phase, out-of-range steering
    task automatic test_extremes();
        send_pair(make_pair(-32768, -32768, -32768, -32768, -32768, -32768, 65535, 1));
        send_pair(make_pair(32767, 32767, 32767, 32767, 32767, 32767, 65535, 1));
        send_pair(make_pair(32767, 0, 32767, 0, 16384, 0, 4096, 1));
        send_pair(make_pair(32767, 0, 32767, 0, -16384, 0, 4096, 1));
        send_pair(make_pair(-32768, 0, 0, 32767, 0, 16384, 1, 0));
        send_pair(make_pair(1, 0, 1, 0, 0, 0, 0, 0));
        send_pair(make_pair(1, -1, -1, 1, 16384, -16384, 32768, 1));
        send_pair(make_pair(-21846, 21845, 12345, -12345, 11585, 11585, 12288, 1));
    endtask

    // zero cross-spectrum sets the flag, and the flag clears after the result
    task automatic test_degenerate();
        send_pair(make_pair(0, 0, 1000, -1000, 16384, 0, 4096, 0));
        send_pair(make_pair(5000, 5000, 6000, 0, 0, 16384, 4096, 1));
        send_pair(make_pair(7000, -7000, 0, 0, 16384, 0, 0, 1));
        send_pair(make_pair(7000, -7000, 7000, -7000, 16384, 0, 0, 1));
    endtask

    // a long run without the last mark saturates the sum
    task automatic test_saturation();
        for (int i = 0; i < 70; i++)
            send_pair(make_pair(300 + i, -20, 400, 50, 16384, 0, 0, i == 69));
        wait_results_drained();
    endtask

    // random groups of pairs, a few stray broken groups
    task automatic test_random_groups(input int pairs, input int idle_pct,
                                      input int stall_pct);
        int left;
        int len;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        left = pairs;
        while (left > 0) begin
            len = ($urandom_range(19) == 0) ? $urandom_range(20, 80)
                                            : $urandom_range(1, 8);
            for (int i = 0; i < len && left > 0; i++, left--)
                send_pair(random_pair(i == len - 1 || left == 1));
        end
    endtask

    // receiver ready
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result check
    always @(posedge aclk) begin
        spectrum_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            if (expected_spectra.size() == 0) begin
                report_mismatch("result transaction with nothing expected");
            end else begin
                exp_res = expected_spectra.pop_front();
                if (m_spectrum_value !== exp_res.spectrum_value)
                    report_mismatch($sformatf("spectrum_value %0h expected %0h",
                                    m_spectrum_value, exp_res.spectrum_value));
                if (m_degenerate_seen !== exp_res.degenerate_seen)
                    report_mismatch($sformatf("degenerate_seen %0b expected %0b",
                                    m_degenerate_seen, exp_res.degenerate_seen));
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_first_re     = '0;
        s_first_im     = '0;
        s_second_re    = '0;
        s_second_im    = '0;
        s_steer_cos    = '0;
        s_steer_sin    = '0;
        s_pair_weight  = '0;
        s_last_pair    = 1'b0;
        m_ready        = 1'b0;
        pred_sum       = '0;
        pred_degen     = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        error_count    = 0;
        cycle_count    = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_extremes();
        test_degenerate();
        test_saturation();
        test_random_groups(300, 0, 0);
        test_random_groups(300, 67, 0);
        wait_results_drained();
        test_random_groups(300, 0, 67);
        test_random_groups(300, 19, 19);

        // drain
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_spectra.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/npsa_pkg.sv
src/npsa_datapath.sv
src/npsa_ctrl.sv
src/nonlinear_phase_spectrum_accumulator_unit.sv
tb/tb_top.sv
